>>> hw/rtl/boi_pkg.sv
package boi_pkg;

	localparam int unsigned CORDIC_STEPS = 24;
	localparam int unsigned DIV_BITS = 74;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
	localparam logic [13:0] STEER_LIMIT = 14'd12867;
	localparam logic [30:0] RATE_MAX = 31'h7FFF_FFFF;
	localparam logic [9:0] MS_PER_S = 10'd1000;

	localparam logic CFG_METERS_PER_TICK = 1'b0;
	localparam logic CFG_INV_WHEELBASE = 1'b1;

	localparam logic [23:0] METERS_PER_TICK_RST = 24'd1549580;
	localparam logic [23:0] INV_WHEELBASE_RST = 24'd344926;

	typedef enum logic [1:0] {
		JOB_BAD,
		JOB_STILL,
		JOB_MOVE
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic [31:0] dt;
		logic dneg;
		logic [32:0] dmag;
		logic signed [14:0] steer;
	} job_t;

	typedef struct packed {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic [31:0] heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] yaw_rate;
		logic bad_interval;
	} result_t;

	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/boi_fifo.sv
module boi_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [W-1:0] rdata,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/boi_mul.sv
module boi_mul (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [63:0] a,
	input logic [63:0] b,
	output logic done,
	output logic [127:0] prod
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [127:0] acc_q;
	logic [63:0] pp_s1;
	logic [1:0] sh_s1;
	logic ppv_s1;
	logic [2:0] idx_q;
	logic busy_q;
	logic done_q;
	logic [31:0] a_limb;
	logic [31:0] b_limb;
	logic [127:0] pp_shifted;

	assign a_limb = idx_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_limb = idx_q[0] ? b_q[63:32] : b_q[31:0];
	assign done = done_q;
	assign prod = acc_q;

	always_comb begin
		case (sh_s1)
			2'd0: pp_shifted = {64'd0, pp_s1};
			2'd1: pp_shifted = {32'd0, pp_s1, 32'd0};
			2'd2: pp_shifted = {pp_s1, 64'd0};
			default: pp_shifted = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
		end
		pp_s1 <= a_limb * b_limb;
		sh_s1 <= {1'b0, idx_q[1]} + {1'b0, idx_q[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ppv_s1 <= 1'b0;
			idx_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
			if (go) begin
				acc_q <= '0;
				idx_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (idx_q != 3'd4) begin
					ppv_s1 <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				if (ppv_s1) begin
					acc_q <= acc_q + pp_shifted;
				end
			end
		end
	end

endmodule

>>> hw/rtl/boi_div.sv
module boi_div (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [boi_pkg::DIV_BITS-1:0] n,
	input logic [31:0] d,
	output logic done,
	output logic [boi_pkg::DIV_BITS-1:0] q
);

	localparam int NB = boi_pkg::DIV_BITS;
	localparam int CB = $clog2(NB);

	logic [NB-1:0] nq_q;
	logic [31:0] rem_q;
	logic [31:0] d_q;
	logic [CB-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] trial;
	logic ge;
	logic [32:0] diff;

	assign trial = {rem_q, nq_q[NB-1]};
	assign ge = trial >= {1'b0, d_q};
	assign diff = trial - {1'b0, d_q};
	assign done = done_q;
	assign q = nq_q;

	always_ff @(posedge clk) begin
		if (go) begin
			d_q <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nq_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				nq_q <= n;
				rem_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				nq_q <= {nq_q[NB-2:0], ge};
				rem_q <= ge ? diff[31:0] : trial[31:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CB'(NB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/boi_cordic.sv
module boi_cordic (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [31:0] ang,
	output logic done,
	output logic signed [31:0] c,
	output logic signed [31:0] s
);

	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic [1:0] quad_q;
	logic [4:0] i_q;
	logic busy_q;
	logic done_q;
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] at;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed({2'b00, boi_pkg::atan_turn(i_q)});
	assign done = done_q;

	always_comb begin
		case (quad_q)
			2'd0: begin
				c = x_q;
				s = y_q;
			end
			2'd1: begin
				c = -y_q;
				s = x_q;
			end
			2'd2: begin
				c = -x_q;
				s = -y_q;
			end
			default: begin
				c = y_q;
				s = -x_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			quad_q <= '0;
			i_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				x_q <= boi_pkg::CORDIC_GAIN;
				y_q <= '0;
				z_q <= $signed({2'b00, ang[29:0]});
				quad_q <= ang[31:30];
				i_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!z_q[31]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 1'b1;
				if (i_q == 5'(boi_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/boi_front.sv
module boi_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [31:0] time_ms,
	input logic signed [31:0] left_count,
	input logic signed [31:0] right_count,
	input logic signed [14:0] steering,
	input logic job_full,
	output logic job_push,
	output boi_pkg::job_t job
);

	logic primed_q;
	logic [31:0] prev_time_q;
	logic signed [32:0] prev_sum_q;
	logic signed [32:0] sum;
	logic signed [33:0] dsum;
	logic [33:0] dabs;
	logic [31:0] dt;
	logic accept;

	assign sum = {left_count[31], left_count} + {right_count[31], right_count};
	assign dsum = {sum[32], sum} - {prev_sum_q[32], prev_sum_q};
	assign dabs = dsum[33] ? 34'(-dsum) : 34'(dsum);
	assign dt = time_ms - prev_time_q;
	assign accept = push && !job_full;
	assign job_push = accept && primed_q;

	always_comb begin
		job.dt = dt;
		job.dneg = dsum[33];
		job.dmag = dabs[32:0];
		job.steer = steering;
		if (dt == '0) begin
			job.kind = boi_pkg::JOB_BAD;
		end else if (dsum == '0) begin
			job.kind = boi_pkg::JOB_STILL;
		end else begin
			job.kind = boi_pkg::JOB_MOVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			prev_time_q <= '0;
			prev_sum_q <= '0;
		end else if (accept) begin
			primed_q <= 1'b1;
			prev_time_q <= time_ms;
			prev_sum_q <= sum;
		end
	end

endmodule

>>> hw/rtl/boi_back.sv
module boi_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [23:0] cfg_data,
	input logic job_valid,
	input boi_pkg::job_t job,
	output logic job_pop,
	input logic res_full,
	output logic res_push,
	output boi_pkg::result_t res
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_D, ST_CS, ST_AX, ST_AY, ST_VXM, ST_VXD, ST_VYM, ST_VYD,
		ST_BA, ST_TCS, ST_TAN, ST_P, ST_DP, ST_DTH, ST_WM, ST_WD, ST_EMIT
	} state_t;

	localparam int NB = boi_pkg::DIV_BITS;

	state_t state_q;
	boi_pkg::job_t job_q;
	logic [23:0] mpt_q;
	logic [23:0] iwb_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic [31:0] angle_q;
	logic [63:0] d_q;
	logic signed [31:0] c_q;
	logic signed [31:0] s_q;
	logic [63:0] ax_q;
	logic [63:0] ay_q;
	logic [63:0] h_q;
	logic hsat_q;
	logic [31:0] dth_q;
	logic [31:0] vx_q;
	logic [31:0] vy_q;
	logic [31:0] wz_q;
	logic bad_q;

	logic mul_go_q;
	logic [63:0] mul_a_q;
	logic [63:0] mul_b_q;
	logic mul_done;
	logic [127:0] mul_prod;
	logic div_go_q;
	logic [NB-1:0] div_n_q;
	logic [31:0] div_d_q;
	logic div_done;
	logic [NB-1:0] div_q;
	logic cor_go_q;
	logic [31:0] cor_ang_q;
	logic cor_done;
	logic signed [31:0] cor_c;
	logic signed [31:0] cor_s;

	logic [14:0] smag;
	logic [13:0] sclamp;
	logic steer_nz;
	logic moving;
	logic signed [31:0] tc;
	logic signed [31:0] ts;
	logic signed [31:0] nx;
	logic signed [31:0] ny;
	logic [31:0] nang;

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [31:0] rate_word(input logic [NB-1:0] q, input logic neg,
		input logic sat);
		logic [31:0] mag;
		mag = (sat || q[NB-1:46] != '0) ? {1'b0, boi_pkg::RATE_MAX} : {1'b0, q[45:15]};
		return neg ? 32'(-mag) : mag;
	endfunction

	function automatic logic signed [31:0] move_pos(input logic signed [31:0] p,
		input logic neg, input logic [63:0] a);
		logic [48:0] d;
		logic [40:0] dc;
		logic signed [42:0] v;
		d = a[63:15];
		dc = (d > 49'h100_0000_0000) ? 41'h100_0000_0000 : d[40:0];
		v = neg ? {{11{p[31]}}, p} - $signed({2'b00, dc}) : {{11{p[31]}}, p} + $signed({2'b00, dc});
		if (v > 43'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -43'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	boi_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .prod(mul_prod)
	);

	boi_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .n(div_n_q), .d(div_d_q),
		.done(div_done), .q(div_q)
	);

	boi_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .go(cor_go_q), .ang(cor_ang_q),
		.done(cor_done), .c(cor_c), .s(cor_s)
	);

	assign smag = job_q.steer[14] ? 15'(-job_q.steer) : 15'(job_q.steer);
	assign sclamp = (smag > {1'b0, boi_pkg::STEER_LIMIT}) ? boi_pkg::STEER_LIMIT : smag[13:0];
	assign steer_nz = (job_q.steer != '0);
	assign moving = (job_q.kind == boi_pkg::JOB_MOVE);
	assign tc = (cor_c < 32'sd1) ? 32'sd1 : cor_c;
	assign ts = cor_s[31] ? 32'sd0 : cor_s;

	assign nx = moving ? move_pos(pos_x_q, job_q.dneg ^ c_q[31], ax_q) : pos_x_q;
	assign ny = moving ? move_pos(pos_y_q, job_q.dneg ^ s_q[31], ay_q) : pos_y_q;

	always_comb begin
		nang = angle_q;
		if (moving && steer_nz) begin
			nang = (job_q.dneg != job_q.steer[14]) ? angle_q - dth_q : angle_q + dth_q;
		end
	end

	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign res_push = (state_q == ST_EMIT) && !res_full;

	always_comb begin
		res.x_pos = nx;
		res.y_pos = ny;
		res.heading = nang;
		res.vel_x = vx_q;
		res.vel_y = vy_q;
		res.yaw_rate = wz_q;
		res.bad_interval = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= '0;
			mpt_q <= boi_pkg::METERS_PER_TICK_RST;
			iwb_q <= boi_pkg::INV_WHEELBASE_RST;
			pos_x_q <= '0;
			pos_y_q <= '0;
			angle_q <= '0;
			d_q <= '0;
			c_q <= '0;
			s_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			h_q <= '0;
			hsat_q <= 1'b0;
			dth_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			wz_q <= '0;
			bad_q <= 1'b0;
			mul_go_q <= 1'b0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			div_go_q <= 1'b0;
			div_n_q <= '0;
			div_d_q <= '0;
			cor_go_q <= 1'b0;
			cor_ang_q <= '0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			cor_go_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					boi_pkg::CFG_METERS_PER_TICK: mpt_q <= cfg_data;
					boi_pkg::CFG_INV_WHEELBASE: iwb_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						vx_q <= '0;
						vy_q <= '0;
						wz_q <= '0;
						bad_q <= (job.kind == boi_pkg::JOB_BAD);
						if (job.kind == boi_pkg::JOB_MOVE) begin
							mul_go_q <= 1'b1;
							mul_a_q <= {31'd0, job.dmag};
							mul_b_q <= {40'd0, mpt_q};
							state_q <= ST_D;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_D: begin
					if (mul_done) begin
						d_q <= mul_prod[63:0];
						cor_go_q <= 1'b1;
						cor_ang_q <= angle_q;
						state_q <= ST_CS;
					end
				end
				ST_CS: begin
					if (cor_done) begin
						c_q <= cor_c;
						s_q <= cor_s;
						mul_go_q <= 1'b1;
						mul_a_q <= d_q;
						mul_b_q <= {32'd0, abs32(cor_c)};
						state_q <= ST_AX;
					end
				end
				ST_AX: begin
					if (mul_done) begin
						ax_q <= mul_prod[95:32];
						mul_go_q <= 1'b1;
						mul_a_q <= d_q;
						mul_b_q <= {32'd0, abs32(s_q)};
						state_q <= ST_AY;
					end
				end
				ST_AY: begin
					if (mul_done) begin
						ay_q <= mul_prod[95:32];
						mul_go_q <= 1'b1;
						mul_a_q <= ax_q;
						mul_b_q <= {54'd0, boi_pkg::MS_PER_S};
						state_q <= ST_VXM;
					end
				end
				ST_VXM: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						div_n_q <= mul_prod[NB-1:0];
						div_d_q <= job_q.dt;
						state_q <= ST_VXD;
					end
				end
				ST_VXD: begin
					if (div_done) begin
						vx_q <= rate_word(div_q, job_q.dneg ^ c_q[31], 1'b0);
						mul_go_q <= 1'b1;
						mul_a_q <= ay_q;
						mul_b_q <= {54'd0, boi_pkg::MS_PER_S};
						state_q <= ST_VYM;
					end
				end
				ST_VYM: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						div_n_q <= mul_prod[NB-1:0];
						div_d_q <= job_q.dt;
						state_q <= ST_VYD;
					end
				end
				ST_VYD: begin
					if (div_done) begin
						vy_q <= rate_word(div_q, job_q.dneg ^ s_q[31], 1'b0);
						if (steer_nz) begin
							mul_go_q <= 1'b1;
							mul_a_q <= {50'd0, sclamp};
							mul_b_q <= {34'd0, boi_pkg::TURN_PER_RAD};
							state_q <= ST_BA;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_BA: begin
					if (mul_done) begin
						cor_go_q <= 1'b1;
						cor_ang_q <= mul_prod[44:13];
						state_q <= ST_TCS;
					end
				end
				ST_TCS: begin
					if (cor_done) begin
						div_go_q <= 1'b1;
						div_n_q <= {27'd0, ts[30:0], 16'd0};
						div_d_q <= tc;
						state_q <= ST_TAN;
					end
				end
				ST_TAN: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						mul_a_q <= div_q[63:0];
						mul_b_q <= {40'd0, iwb_q};
						state_q <= ST_P;
					end
				end
				ST_P: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						mul_a_q <= d_q;
						mul_b_q <= mul_prod[63:0];
						state_q <= ST_DP;
					end
				end
				ST_DP: begin
					if (mul_done) begin
						h_q <= mul_prod[97:34];
						hsat_q <= (mul_prod[127:98] != '0);
						mul_go_q <= 1'b1;
						mul_a_q <= mul_prod[97:34];
						mul_b_q <= {34'd0, boi_pkg::TURN_PER_RAD};
						state_q <= ST_DTH;
					end
				end
				ST_DTH: begin
					if (mul_done) begin
						dth_q <= mul_prod[62:31];
						mul_go_q <= 1'b1;
						mul_a_q <= h_q;
						mul_b_q <= {54'd0, boi_pkg::MS_PER_S};
						state_q <= ST_WM;
					end
				end
				ST_WM: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						div_n_q <= mul_prod[NB-1:0];
						div_d_q <= job_q.dt;
						state_q <= ST_WD;
					end
				end
				ST_WD: begin
					if (div_done) begin
						wz_q <= rate_word(div_q, job_q.dneg ^ job_q.steer[14], hsat_q);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						pos_x_q <= nx;
						pos_y_q <= ny;
						angle_q <= nang;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/bicycle_odometry_integrator_core.sv
// Dead-reckoning odometry for a bicycle-model vehicle. Samples are pushed as words of timestamp,
// two cumulative wheel counts and steering angle; the first sample after reset only primes the
// block and gives no result, every later sample gives exactly one pose word. A two-entry sample
// queue and a two-entry result queue sit either side of a single sequencer that works on one
// sample at a time, sharing one 64x64 multiplier, one rotation unit and one 74-step divider. A
// sample with a zero interval or no wheel travel skips the arithmetic; a moving sample runs the
// divider once per velocity and, with nonzero steering, once each for the steering tangent and
// yaw rate. Registers are written through the always-ready configuration channel; the user must
// write them only while no sample is in flight, which the block itself does not enforce.
module bicycle_odometry_integrator_core #(
	parameter int JOB_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [31:0] time_ms,
	input logic signed [31:0] left_count,
	input logic signed [31:0] right_count,
	input logic signed [14:0] steering,
	output logic empty,
	input logic pop,
	output logic signed [31:0] x_pos,
	output logic signed [31:0] y_pos,
	output logic [31:0] heading,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate,
	output logic bad_interval,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [23:0] cfg_data
);

	localparam int JW = $bits(boi_pkg::job_t);
	localparam int RW = $bits(boi_pkg::result_t);

	boi_pkg::job_t job_in;
	boi_pkg::job_t job_out;
	logic [JW-1:0] job_bits;
	logic job_push;
	logic job_empty;
	logic job_pop;
	boi_pkg::result_t res_in;
	boi_pkg::result_t res_out;
	logic [RW-1:0] res_bits;
	logic res_push;
	logic res_full;

	assign cfg_ready = 1'b1;
	assign job_out = job_bits;
	assign res_out = res_bits;

	boi_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .time_ms(time_ms),
		.left_count(left_count), .right_count(right_count), .steering(steering),
		.job_full(full), .job_push(job_push), .job(job_in)
	);

	boi_fifo #(.W(JW), .DEPTH(JOB_DEPTH)) u_job_q (
		.clk(clk), .arst_n(arst_n), .push(job_push), .wdata(job_in), .full(full),
		.pop(job_pop), .rdata(job_bits), .empty(job_empty)
	);

	boi_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .job_valid(!job_empty), .job(job_out), .job_pop(job_pop),
		.res_full(res_full), .res_push(res_push), .res(res_in)
	);

	boi_fifo #(.W(RW), .DEPTH(RES_DEPTH)) u_res_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .wdata(res_in), .full(res_full),
		.pop(pop), .rdata(res_bits), .empty(empty)
	);

	assign x_pos = res_out.x_pos;
	assign y_pos = res_out.y_pos;
	assign heading = res_out.heading;
	assign vel_x = res_out.vel_x;
	assign vel_y = res_out.vel_y;
	assign yaw_rate = res_out.yaw_rate;
	assign bad_interval = res_out.bad_interval;

endmodule

>>> hw/rtl/boi_checker.sv
module boi_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input logic signed [31:0] x_pos,
	input logic signed [31:0] y_pos,
	input logic [31:0] heading,
	input logic signed [31:0] vel_x,
	input logic signed [31:0] vel_y,
	input logic signed [31:0] yaw_rate,
	input logic bad_interval
);

	// No word can be waiting in the first cycle after reset is released.
	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> empty)
		else $error("result word present straight after reset");

	// A word held back by the consumer stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(x_pos) && $stable(y_pos) && $stable(heading)
			&& $stable(vel_x) && $stable(vel_y) && $stable(yaw_rate) && $stable(bad_interval)))
		else $error("result word changed while stalled");

	// The result queue only drains through the consumer.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result word vanished without a pop");

	// A zero interval reports no motion.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && bad_interval) |-> (vel_x == '0 && vel_y == '0 && yaw_rate == '0))
		else $error("non-zero rate on a zero interval");

endmodule

bind bicycle_odometry_integrator_core boi_checker u_boi_checker (.*);
